[design/sem_psv_element_force_defines.svh]
// Assertion macros for the spectral element force block
`ifndef SEM_PSV_ELEMENT_FORCE_DEFINES_SVH
`define SEM_PSV_ELEMENT_FORCE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SPEF_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SPEF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/spef_pkg.sv]
// Shared types and constants of the spectral element force block
package spef_pkg;

  localparam int DATA_W  = 32;
  localparam int FORCE_W = 48;
  localparam int MAT_N   = 6;
  localparam int SLOT_W  = 6;

  localparam logic [1:0] CMD_H    = 2'd0;
  localparam logic [1:0] CMD_HT   = 2'd1;
  localparam logic [1:0] CMD_NODE = 2'd2;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [SLOT_W-1:0]             slot;
    logic                          last;
    logic [DATA_W-1:0]             coef;
    logic [DATA_W-1:0]             disp_x;
    logic [DATA_W-1:0]             disp_z;
    logic [MAT_N-1:0][DATA_W-1:0]  mat;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/spef_front.sv]
// Front end: takes input beats, classifies them and counts nodes
module spef_front #(
  parameter int N = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                func,
  input  logic [5:0]          coef_index,
  input  logic signed [31:0]  coef_value,
  input  logic signed [31:0]  disp_x,
  input  logic signed [31:0]  disp_z,
  input  logic signed [31:0]  mat0,
  input  logic signed [31:0]  mat1,
  input  logic signed [31:0]  mat2,
  input  logic signed [31:0]  mat3,
  input  logic signed [31:0]  mat4,
  input  logic signed [31:0]  mat5,
  input  spef_pkg::q_status_t q_st,
  output logic                push,
  output spef_pkg::cmd_t      cmd
);
  import spef_pkg::*;

  localparam int NN = N * N;
  localparam int CW = $clog2(NN);

  logic [CW-1:0] cnt;
  logic          fire;
  logic          in_h;
  logic          in_ht;
  logic          node_last;
  int            idx;

  always_comb begin
    idx        = int'(coef_index);
    item_ready = !q_st.full;
    fire       = item_valid && item_ready;
    in_h       = idx < NN;
    in_ht      = (idx >= NN) && (idx < 2 * NN);
    node_last  = cnt == CW'(NN - 1);
    push       = fire && (func || in_h || in_ht);
    cmd.kind   = func ? CMD_NODE : (in_h ? CMD_H : CMD_HT);
    cmd.slot   = func ? SLOT_W'(cnt) : (in_h ? coef_index : SLOT_W'(idx - NN));
    cmd.last   = func && node_last;
    cmd.coef   = coef_value;
    cmd.disp_x = disp_x;
    cmd.disp_z = disp_z;
    cmd.mat    = {mat5, mat4, mat3, mat2, mat1, mat0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (fire && func) begin
      cnt <= node_last ? '0 : cnt + CW'(1);
    end
  end

endmodule

[design/spef_queue.sv]
// Two-entry command queue between front and back
module spef_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  spef_pkg::cmd_t      din,
  input  logic                pop,
  output spef_pkg::cmd_t      head,
  output spef_pkg::q_status_t st
);
  import spef_pkg::*;

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign head     = slots[rp];
  assign st.full  = cnt == 2'd2;
  assign st.empty = cnt == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/spef_mul.sv]
// Multi-cycle Q8.24 by Q24.24 multiplier, truncating and saturating to 48 bits
module spef_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [31:0]   x,
  input  logic signed [47:0]   y,
  output logic                 done,
  output logic signed [47:0]   res
);
  import spef_pkg::*;

  localparam int H_W   = FORCE_W / 2;
  localparam int P_W   = DATA_W + H_W;
  localparam int SUM_W = P_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LO   = 2'd1;
  localparam logic [1:0] ST_HI   = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  localparam logic [SUM_W-1:0] LIM =
    {{(SUM_W-FORCE_W){1'b0}}, 1'b1, {(FORCE_W-1){1'b0}}};
  localparam logic [FORCE_W-1:0] QMAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] QMIN = {1'b1, {(FORCE_W-1){1'b0}}};

  logic [1:0]         state;
  logic [DATA_W-1:0]  ax;
  logic [FORCE_W-1:0] ay;
  logic               neg;
  logic [P_W-1:0]     pp_lo;
  logic [P_W-1:0]     pp_hi;
  logic [H_W-1:0]     mul_b;
  logic [P_W-1:0]     prod;
  logic [SUM_W-1:0]   sum;
  logic [FORCE_W-1:0] sat;

  always_comb begin
    mul_b = (state == ST_LO) ? ay[H_W-1:0] : ay[FORCE_W-1:H_W];
    prod  = P_W'(ax) * P_W'(mul_b);
    sum   = {1'b0, pp_hi} + {{(SUM_W-(P_W-H_W)){1'b0}}, pp_lo[P_W-1:H_W]};
    if (neg) begin
      sat = (sum > LIM) ? QMIN : -sum[FORCE_W-1:0];
    end else begin
      sat = (sum >= LIM) ? QMAX : sum[FORCE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: if (start) state <= ST_LO;
        ST_LO:   state <= ST_HI;
        ST_HI:   state <= ST_SUM;
        ST_SUM: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      ax  <= x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
      ay  <= y[FORCE_W-1] ? FORCE_W'(-y) : FORCE_W'(y);
      neg <= x[DATA_W-1] ^ y[FORCE_W-1];
    end
    if (state == ST_LO) pp_lo <= prod;
    if (state == ST_HI) pp_hi <= prod;
    if (state == ST_SUM) res <= sat;
  end

endmodule

[design/spef_back.sv]
// Back end: element stores and the sequencer that forms derivatives, stresses and forces
module spef_back #(
  parameter int N = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  spef_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [4:0]         node_index,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_z,
  output logic               last
);
  import spef_pkg::*;

  localparam int NN = N * N;
  localparam int PW = $clog2(NN);
  localparam int IW = $clog2(N);
  localparam int CW = (IW < 2) ? 2 : IW;
  localparam int AW = FORCE_W + $clog2(2 * N) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_OPER = 3'd2;
  localparam logic [2:0] S_MULW = 3'd3;
  localparam logic [2:0] S_GRP  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam logic [1:0] PH_DER = 2'd0;
  localparam logic [1:0] PH_STR = 2'd1;
  localparam logic [1:0] PH_FRC = 2'd2;

  localparam logic signed [AW-1:0] QMAX = AW'({1'b0, {(FORCE_W-1){1'b1}}});
  localparam logic signed [AW-1:0] QMIN = -QMAX - AW'(1);

  function automatic logic [PW-1:0] lin(input int r, input int c);
    return PW'(r * N + c);
  endfunction

  function automatic logic signed [FORCE_W-1:0] sat(input logic signed [AW-1:0] v);
    if (v > QMAX) return {1'b0, {(FORCE_W-1){1'b1}}};
    if (v < QMIN) return {1'b1, {(FORCE_W-1){1'b0}}};
    return v[FORCE_W-1:0];
  endfunction

  function automatic logic signed [AW-1:0] ext(input logic signed [FORCE_W-1:0] v);
    return {{(AW-FORCE_W){v[FORCE_W-1]}}, v};
  endfunction

  logic [2:0]                state;
  logic [1:0]                phase;
  logic [IW-1:0]             ci;
  logic [IW-1:0]             cj;
  logic [1:0]                cf;
  logic [CW-1:0]             ck;
  logic                      ct;
  logic signed [AW-1:0]      acc;
  logic signed [FORCE_W-1:0] fx_hold;
  logic signed [FORCE_W-1:0] fz_hold;

  logic [DATA_W-1:0]  h_mem   [NN];
  logic [DATA_W-1:0]  ht_mem  [NN];
  logic [DATA_W-1:0]  dx_mem  [NN];
  logic [DATA_W-1:0]  dz_mem  [NN];
  logic [DATA_W-1:0]  mat_mem [MAT_N][NN];
  logic [FORCE_W-1:0] grad_mem [4][NN];
  logic [FORCE_W-1:0] str_mem  [4][NN];

  logic signed [DATA_W-1:0]  h_rd;
  logic signed [DATA_W-1:0]  ht_rd;
  logic signed [DATA_W-1:0]  dx_rd;
  logic signed [DATA_W-1:0]  dz_rd;
  logic signed [DATA_W-1:0]  mat_rd  [MAT_N];
  logic signed [FORCE_W-1:0] grad_rd [4];
  logic signed [FORCE_W-1:0] str_rd  [4];

  logic [PW-1:0] p_a;
  logic [PW-1:0] ik_a;
  logic [PW-1:0] kj_a;
  logic [PW-1:0] h_a;
  logic [PW-1:0] ht_a;
  logic [PW-1:0] d_a;

  logic [2:0]                sel_mi;
  logic [1:0]                sel_gi;
  logic                      sel_byp;
  logic                      sel_acc;
  logic                      byp_now;
  logic signed [DATA_W-1:0]  op_x;
  logic signed [FORCE_W-1:0] op_y;
  logic signed [DATA_W-1:0]  d_sel;
  logic                      term_last;
  logic                      term_done;
  logic                      node_last;
  logic                      mul_start;
  logic                      mul_done;
  logic signed [FORCE_W-1:0] mul_res;

  spef_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (op_x),
    .y     (op_y),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_comb begin
    p_a  = lin(int'(ci), int'(cj));
    ik_a = lin(int'(ci), int'(ck));
    kj_a = lin(int'(ck), int'(cj));
    h_a  = (phase == PH_DER) ? kj_a : ik_a;
    ht_a = (phase == PH_DER) ? ik_a : kj_a;
    d_a  = cf[1] ? ik_a : kj_a;

    sel_mi  = 3'd0;
    sel_gi  = 2'd0;
    sel_byp = 1'b0;
    sel_acc = 1'b0;
    case ({cf, ck[1:0]})
      4'b00_00: begin sel_mi = 3'd0; sel_gi = 2'd0; end
      4'b00_01: begin sel_mi = 3'd1; sel_gi = 2'd3; end
      4'b01_00: begin sel_byp = 1'b1; sel_gi = 2'd2; end
      4'b01_01: begin sel_byp = 1'b1; sel_gi = 2'd1; end
      4'b01_10: begin sel_mi = 3'd3; sel_acc = 1'b1; end
      4'b10_00: begin sel_mi = 3'd4; sel_gi = 2'd2; end
      4'b10_01: begin sel_mi = 3'd5; sel_gi = 2'd1; end
      4'b11_00: begin sel_mi = 3'd1; sel_gi = 2'd0; end
      4'b11_01: begin sel_mi = 3'd2; sel_gi = 2'd3; end
      default:  begin sel_mi = 3'd0; sel_gi = 2'd0; end
    endcase

    d_sel = cf[0] ? dz_rd : dx_rd;
    case (phase)
      PH_DER: begin
        op_x = cf[1] ? h_rd : ht_rd;
        op_y = {{(FORCE_W-DATA_W){d_sel[DATA_W-1]}}, d_sel};
      end
      PH_STR: begin
        op_x = mat_rd[sel_mi];
        op_y = sel_acc ? sat(acc) : grad_rd[sel_gi];
      end
      PH_FRC: begin
        op_x = ct ? ht_rd : h_rd;
        op_y = ct ? (cf[0] ? str_rd[3] : str_rd[1]) : (cf[0] ? str_rd[2] : str_rd[0]);
      end
      default: begin
        op_x = h_rd;
        op_y = '0;
      end
    endcase

    case (phase)
      PH_DER:  term_last = ck == CW'(N - 1);
      PH_STR:  term_last = (cf == 2'd1) ? (ck == CW'(2)) : (ck == CW'(1));
      default: term_last = (ck == CW'(N - 1)) && ct;
    endcase

    byp_now   = (state == S_OPER) && (phase == PH_STR) && sel_byp;
    mul_start = (state == S_OPER) && !byp_now;
    term_done = byp_now || ((state == S_MULW) && mul_done);
    node_last = (ci == IW'(N - 1)) && (cj == IW'(N - 1));
    cmd_pop   = (state == S_IDLE) && cmd_valid;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      case (cmd.kind)
        CMD_H:  h_mem[cmd.slot[PW-1:0]]  <= cmd.coef;
        CMD_HT: ht_mem[cmd.slot[PW-1:0]] <= cmd.coef;
        CMD_NODE: begin
          dx_mem[cmd.slot[PW-1:0]] <= cmd.disp_x;
          dz_mem[cmd.slot[PW-1:0]] <= cmd.disp_z;
          for (int q = 0; q < MAT_N; q++) begin
            mat_mem[q][cmd.slot[PW-1:0]] <= cmd.mat[q];
          end
        end
        default: ;
      endcase
    end
    if (state == S_GRP && phase == PH_DER) grad_mem[cf][p_a] <= sat(acc);
    if (state == S_GRP && phase == PH_STR) str_mem[cf][p_a]  <= sat(acc);

    h_rd  <= h_mem[h_a];
    ht_rd <= ht_mem[ht_a];
    dx_rd <= dx_mem[d_a];
    dz_rd <= dz_mem[d_a];
    for (int q = 0; q < MAT_N; q++) begin
      mat_rd[q] <= mat_mem[q][p_a];
    end
    for (int g = 0; g < 4; g++) begin
      grad_rd[g] <= grad_mem[g][p_a];
    end
    str_rd[0] <= str_mem[0][kj_a];
    str_rd[1] <= str_mem[1][ik_a];
    str_rd[2] <= str_mem[2][kj_a];
    str_rd[3] <= str_mem[3][ik_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_DER;
      ci           <= '0;
      cj           <= '0;
      cf           <= 2'd0;
      ck           <= '0;
      ct           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (term_done) begin
        if (term_last) begin
          state <= S_GRP;
        end else begin
          state <= S_ADDR;
          if (phase == PH_FRC) begin
            ct <= ~ct;
            if (ct) ck <= ck + CW'(1);
          end else begin
            ck <= ck + CW'(1);
          end
        end
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.kind == CMD_NODE && cmd.last) begin
            state <= S_ADDR;
            phase <= PH_DER;
            ci    <= '0;
            cj    <= '0;
            cf    <= 2'd0;
            ck    <= '0;
            ct    <= 1'b0;
          end
        end
        S_ADDR: state <= S_OPER;
        S_OPER: if (!byp_now) state <= S_MULW;
        S_MULW: ;
        S_GRP: begin
          ck <= '0;
          ct <= 1'b0;
          if (phase == PH_FRC) begin
            if (cf == 2'd0) begin
              cf    <= 2'd1;
              state <= S_ADDR;
            end else begin
              state <= S_EMIT;
            end
          end else if (cf == 2'd3) begin
            cf    <= 2'd0;
            state <= S_ADDR;
            if (node_last) begin
              ci    <= '0;
              cj    <= '0;
              phase <= (phase == PH_DER) ? PH_STR : PH_FRC;
            end else if (cj == IW'(N - 1)) begin
              cj <= '0;
              ci <= ci + IW'(1);
            end else begin
              cj <= cj + IW'(1);
            end
          end else begin
            cf    <= cf + 2'd1;
            state <= S_ADDR;
          end
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            cf <= 2'd0;
            if (node_last) begin
              state <= S_IDLE;
            end else begin
              state <= S_ADDR;
              if (cj == IW'(N - 1)) begin
                cj <= '0;
                ci <= ci + IW'(1);
              end else begin
                cj <= cj + IW'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      acc <= '0;
    end else if (byp_now) begin
      acc <= acc + ext(grad_rd[sel_gi]);
    end else if (state == S_MULW && mul_done) begin
      acc <= (phase == PH_STR && cf == 2'd1) ? ext(mul_res) : acc + ext(mul_res);
    end else if (state == S_GRP) begin
      acc <= '0;
    end
    if (state == S_GRP && phase == PH_FRC && cf == 2'd0) fx_hold <= sat(acc);
    if (state == S_GRP && phase == PH_FRC && cf == 2'd1) fz_hold <= sat(acc);
    if (state == S_EMIT && (!result_valid || result_ready)) begin
      node_index <= 5'(p_a);
      force_x    <= fx_hold;
      force_z    <= fz_hold;
      last       <= node_last;
    end
  end

endmodule

[design/sem_psv_element_force.sv]
// Top level of the P-SV spectral element internal force block
// Coefficient beats (func 0) load H and its transpose; node beats (func 1)
// stream one element's N*N nodes row-major. Beats enter a two-entry queue and
// are taken by the back end one a cycle while it is idle. After the last node
// the back end runs one shared multi-cycle multiplier for 8*N*N*N + 7*N*N
// products per element, and uses two plain adds for each node's shear sum.
// Forces then come out row-major, one beat per node, last set on the final
// one. No new node is stored while an element is being worked on; the queue
// fills, then ready drops.
`include "sem_psv_element_force_defines.svh"

module sem_psv_element_force #(
  parameter int NODES_PER_SIDE = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               func,
  input  logic [5:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] disp_x,
  input  logic signed [31:0] disp_z,
  input  logic signed [31:0] mat0,
  input  logic signed [31:0] mat1,
  input  logic signed [31:0] mat2,
  input  logic signed [31:0] mat3,
  input  logic signed [31:0] mat4,
  input  logic signed [31:0] mat5,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [4:0]         node_index,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_z,
  output logic               last
);
  import spef_pkg::*;

  localparam int NN = NODES_PER_SIDE * NODES_PER_SIDE;

  q_status_t q_st;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;

  spef_front #(.N(NODES_PER_SIDE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .func       (func),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .disp_x     (disp_x),
    .disp_z     (disp_z),
    .mat0       (mat0),
    .mat1       (mat1),
    .mat2       (mat2),
    .mat3       (mat3),
    .mat4       (mat4),
    .mat5       (mat5),
    .q_st       (q_st),
    .push       (push),
    .cmd        (push_cmd)
  );

  spef_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_cmd),
    .pop  (pop),
    .head (head_cmd),
    .st   (q_st)
  );

  spef_back #(.N(NODES_PER_SIDE)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!q_st.empty),
    .cmd          (head_cmd),
    .cmd_pop      (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .node_index   (node_index),
    .force_x      (force_x),
    .force_z      (force_z),
    .last         (last)
  );

  `SPEF_ASSERT_NOW(a_last_index, result_valid && last, node_index == 5'(NN - 1), "last beat not on final node")
  `SPEF_ASSERT_NEXT(a_idle_after_last, result_valid && result_ready && last, !result_valid, "result after element end")
  `SPEF_ASSERT_NEXT(a_node_order, result_valid && result_ready && !last, !result_valid || node_index == $past(node_index) + 5'd1, "node results out of order")

endmodule
